// ----- sv/assert_macros.svh -----
// assertion macros shared by the idle and long-press controller
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IDLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed (same cycle)");
`define IDLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed (next cycle)");
`else
`define IDLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IDLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/idlp_pkg.sv -----
// types, register indexes and codes of the idle and long-press controller
// no dependencies
package idlp_pkg;

	localparam int TIME_BITS = 40;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [TIME_BITS:0]   tsum_t;

	// configuration register indexes
	localparam logic [2:0] REG_IDLE_TIMEOUT   = 3'd0;
	localparam logic [2:0] REG_LONG_PRESS     = 3'd1;
	localparam logic [2:0] REG_BATTERY_PERIOD = 3'd2;
	localparam logic [2:0] REG_AXIS_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_START_IDENTITY = 3'd4;

	localparam logic [31:0] IDLE_TIMEOUT_RST   = 32'd300000;
	localparam logic [15:0] LONG_PRESS_RST     = 16'd3000;
	localparam logic [31:0] BATTERY_PERIOD_RST = 32'd60000;
	localparam logic [14:0] AXIS_THRESHOLD_RST = 15'd4096;
	localparam logic [7:0]  START_IDENTITY_RST = 8'd0;

	// button bit positions
	localparam int BTN_MODE = 0;
	localparam int BTN_HOME = 1;
	localparam int BTN_XD   = 5;

	// b, y, x chord held with mode
	localparam logic [2:0] COMBO_NONE = 3'b000;
	localparam logic [2:0] COMBO_B    = 3'b001;
	localparam logic [2:0] COMBO_Y    = 3'b010;
	localparam logic [2:0] COMBO_X    = 3'b100;

	localparam logic [7:0] GYRO_IDENTITY = 8'd1;

	localparam logic [1:0] ADV_NONE     = 2'd0;
	localparam logic [1:0] ADV_STOP     = 2'd1;
	localparam logic [1:0] ADV_START    = 2'd2;
	localparam logic [1:0] ADV_RESERVED = 2'd3;

	localparam logic CAL_AXES = 1'b0;
	localparam logic CAL_GYRO = 1'b1;

	typedef enum logic [2:0] {
		PH_RELEASED = 3'b001,
		PH_TIMING   = 3'b010,
		PH_FIRED    = 3'b100
	} phase_t;

	typedef struct packed {
		logic [39:0]        now_ms;
		logic [15:0]        button_bits;
		logic               dpad_centered;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] left_trigger;
		logic signed [15:0] right_trigger;
		logic [7:0]         identity_now;
		logic               adv_discoverable;
		logic [6:0]         battery_percent;
	} in_word_t;

	typedef struct packed {
		logic       battery_report;
		logic [6:0] battery_level;
		logic       sleep_request;
		logic       restart_request;
		logic       disconnect_request;
		logic       calibrate_request;
		logic       calibrate_target;
		logic       clear_bonds_request;
		logic [1:0] adv_action;
	} out_word_t;

endpackage

// ----- sv/idlp_ifs.sv -----
// valid/ready channels of the idle and long-press controller
// depends on idlp_pkg for the word types
interface idlp_in_if;
	logic              valid;
	logic              ready;
	idlp_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface idlp_out_if;
	logic               valid;
	logic               ready;
	idlp_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/idlp_activity.sv -----
// activity detect for one poll: buttons, dpad, stick magnitudes, triggers
// depends on idlp_pkg
module idlp_activity (
	input  idlp_pkg::in_word_t word,
	input  logic [14:0]        axis_threshold,
	output logic               active
);

	logic [3:0]  stick_hit;
	logic [1:0]  trig_hit;
	logic [15:0] stick [4];
	logic [15:0] trig [2];
	logic        btn_hit;

	assign stick[0] = word.left_x;
	assign stick[1] = word.left_y;
	assign stick[2] = word.right_x;
	assign stick[3] = word.right_y;
	assign trig[0]  = word.left_trigger;
	assign trig[1]  = word.right_trigger;

	// xd switch never counts as activity
	always_comb begin
		logic [15:0] btn;
		btn = word.button_bits;
		btn[idlp_pkg::BTN_XD] = 1'b0;
		btn_hit = |btn;
	end

	// magnitude in 17 bits so that the most negative value reads as 32768
	always_comb begin
		logic [16:0] ext;
		logic [16:0] mag;
		for (int i = 0; i < 4; i++) begin
			ext = {stick[i][15], stick[i]};
			mag = stick[i][15] ? (~ext + 17'd1) : ext;
			stick_hit[i] = mag > {2'b00, axis_threshold};
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++)
			trig_hit[i] = !trig[i][15] && (trig[i][14:0] > axis_threshold);
	end

	assign active = btn_hit || !word.dpad_centered || (|stick_hit) || (|trig_hit);

endmodule

// ----- sv/idlp_press.sv -----
// long-press tracker for one button: start time and phase registers
// depends on idlp_pkg
module idlp_press (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                held,
	input  idlp_pkg::time_t     now,
	input  logic [15:0]         long_press_ms,
	output logic                fire,
	output idlp_pkg::phase_t    phase
);

	idlp_pkg::phase_t phase_q;
	idlp_pkg::phase_t phase_d;
	idlp_pkg::time_t  start_q;
	logic             elapsed;

	assign elapsed = (now >= start_q) &&
		((now - start_q) >= idlp_pkg::time_t'(long_press_ms));

	always_comb begin
		phase_d = phase_q;
		fire    = 1'b0;
		if (!held) begin
			phase_d = idlp_pkg::PH_RELEASED;
		end else begin
			unique case (phase_q)
				idlp_pkg::PH_RELEASED: phase_d = idlp_pkg::PH_TIMING;
				idlp_pkg::PH_TIMING: begin
					if (elapsed) begin
						phase_d = idlp_pkg::PH_FIRED;
						fire    = 1'b1;
					end
				end
				idlp_pkg::PH_FIRED: phase_d = idlp_pkg::PH_FIRED;
				default: phase_d = idlp_pkg::PH_FIRED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= idlp_pkg::PH_RELEASED;
		end else if (step) begin
			phase_q <= phase_d;
		end
	end

	// start time is only read while timing, so no reset
	always_ff @(posedge clk) begin
		if (step && held && phase_q == idlp_pkg::PH_RELEASED) begin
			start_q <= now;
		end
	end

	assign phase = phase_q;

endmodule

// ----- sv/idle_and_long_press_controller.sv -----
// Idle and long-press controller. One poll word is taken per clock cycle unless the
// result side stalls; its result word passes the input register, then the result
// register, and is then offered on the output. The block sustains one word per
// cycle as long as the result side keeps up. The loop through the last-active,
// battery and press state registers sets that rate.
// Configuration writes apply from the next cycle.
// Depends on idlp_pkg, idlp_ifs, idlp_activity, idlp_press, assert_macros.svh.
`include "assert_macros.svh"

module idle_and_long_press_controller (
	input  logic             clk,
	input  logic             arst_n,
	idlp_in_if.sink          in_ch,
	idlp_out_if.source       out_ch,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [31:0]      cfg_data
);

	// configuration
	logic [31:0] idle_timeout_q;
	logic [15:0] long_press_q;
	logic [31:0] battery_period_q;
	logic [14:0] axis_threshold_q;
	logic [7:0]  start_identity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q   <= idlp_pkg::IDLE_TIMEOUT_RST;
			long_press_q     <= idlp_pkg::LONG_PRESS_RST;
			battery_period_q <= idlp_pkg::BATTERY_PERIOD_RST;
			axis_threshold_q <= idlp_pkg::AXIS_THRESHOLD_RST;
			start_identity_q <= idlp_pkg::START_IDENTITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				idlp_pkg::REG_IDLE_TIMEOUT:   idle_timeout_q   <= cfg_data;
				idlp_pkg::REG_LONG_PRESS:     long_press_q     <= cfg_data[15:0];
				idlp_pkg::REG_BATTERY_PERIOD: battery_period_q <= cfg_data;
				idlp_pkg::REG_AXIS_THRESHOLD: axis_threshold_q <= cfg_data[14:0];
				idlp_pkg::REG_START_IDENTITY: start_identity_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic               valid_s1;
	idlp_pkg::in_word_t word_s1;
	logic               out_valid_q;
	idlp_pkg::out_word_t out_word_q;
	logic               out_free;
	logic               step;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign step        = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			word_s1 <= in_ch.data;
		end
	end

	// poll evaluation
	idlp_pkg::time_t  now;
	idlp_pkg::time_t  last_active_q;
	idlp_pkg::time_t  next_battery_q;
	idlp_pkg::tsum_t  batt_sum;
	idlp_pkg::phase_t mode_phase;
	idlp_pkg::phase_t home_phase;
	logic             active;
	logic             batt_due;
	logic             idle_sleep;
	logic             ident_moved;
	logic             mode_fire;
	logic             home_fire;
	logic             fire_in_timing;
	logic [2:0]       combo;
	idlp_pkg::out_word_t res;

	assign now = idlp_pkg::time_t'(word_s1.now_ms);

	idlp_activity u_activity (
		.word           (word_s1),
		.axis_threshold (axis_threshold_q),
		.active         (active)
	);

	idlp_press u_mode_press (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.held          (word_s1.button_bits[idlp_pkg::BTN_MODE]),
		.now           (now),
		.long_press_ms (long_press_q),
		.fire          (mode_fire),
		.phase         (mode_phase)
	);

	idlp_press u_home_press (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.held          (word_s1.button_bits[idlp_pkg::BTN_HOME]),
		.now           (now),
		.long_press_ms (long_press_q),
		.fire          (home_fire),
		.phase         (home_phase)
	);

	assign batt_due = now > next_battery_q;
	assign batt_sum = {1'b0, now} + idlp_pkg::tsum_t'(battery_period_q);

	// an active poll moves last-active to now, which can never time out
	assign idle_sleep = !active && (now > last_active_q) &&
		((now - last_active_q) > idlp_pkg::time_t'(idle_timeout_q));

	assign ident_moved = word_s1.identity_now != start_identity_q;
	assign combo       = word_s1.button_bits[4:2];

	always_comb begin
		res = '0;
		res.battery_report     = batt_due;
		res.battery_level      = batt_due ? word_s1.battery_percent : 7'd0;
		res.sleep_request      = idle_sleep || home_fire;
		res.restart_request    = ident_moved;
		res.disconnect_request = ident_moved || home_fire;
		res.calibrate_target   = idlp_pkg::CAL_AXES;
		res.adv_action         = idlp_pkg::ADV_NONE;
		if (mode_fire) begin
			case (combo)
				idlp_pkg::COMBO_B: res.calibrate_request = 1'b1;
				idlp_pkg::COMBO_Y: begin
					res.clear_bonds_request = 1'b1;
					res.restart_request     = 1'b1;
				end
				idlp_pkg::COMBO_X: begin
					if (word_s1.identity_now == idlp_pkg::GYRO_IDENTITY) begin
						res.calibrate_request = 1'b1;
						res.calibrate_target  = idlp_pkg::CAL_GYRO;
					end
				end
				idlp_pkg::COMBO_NONE: res.adv_action = word_s1.adv_discoverable ?
					idlp_pkg::ADV_STOP : idlp_pkg::ADV_START;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_active_q  <= '0;
			next_battery_q <= '0;
		end else if (step) begin
			if (active) begin
				last_active_q <= now;
			end
			// saturate at the top of the time range
			if (batt_due) begin
				next_battery_q <= batt_sum[idlp_pkg::TIME_BITS] ? '1 :
					batt_sum[idlp_pkg::TIME_BITS-1:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_word_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_word_q;

	// a press only completes out of the timing phase
	assign fire_in_timing = (!home_fire || home_phase == idlp_pkg::PH_TIMING) &&
		(!mode_fire || mode_phase == idlp_pkg::PH_TIMING);

	`IDLP_ASSERT_IMP(a_target_needs_cal, clk, arst_n, out_ch.valid && out_ch.data.calibrate_target, out_ch.data.calibrate_request)
	`IDLP_ASSERT_IMP(a_adv_code_valid, clk, arst_n, out_ch.valid, out_ch.data.adv_action != idlp_pkg::ADV_RESERVED)
	`IDLP_ASSERT_NXT(a_battery_moves_ahead, clk, arst_n, step && batt_due, next_battery_q >= $past(now))
	`IDLP_ASSERT_NXT(a_stalled_word_held, clk, arst_n, valid_s1 && !out_free, valid_s1 && $stable(word_s1))
	`IDLP_ASSERT_IMP(a_fire_from_timing, clk, arst_n, step, fire_in_timing)

endmodule
